FILE: hdl/curvature_extrema_detector_macros.svh
// Assertion macros for the curvature extrema detector.
// Included by the top level; needs nothing else.
`ifndef CURVATURE_EXTREMA_DETECTOR_MACROS_SVH
`define CURVATURE_EXTREMA_DETECTOR_MACROS_SVH

// Check that a condition implies another in the same cycle.
`define CED_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("curvature_extrema_detector: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define CED_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("curvature_extrema_detector: next-cycle check failed");

`endif

FILE: hdl/ced_pkg.sv
// Shared widths, register codes, types and helpers for the curvature
// extrema detector. No dependencies.
package ced_pkg;

  // Curve length limit; the point counter saturates at MAX_POINTS-1
  localparam int MAX_POINTS = 4096;
  localparam int CNT_W      = $clog2(MAX_POINTS);

  // Field widths
  localparam int CURV_W    = 48;
  localparam int ARC_W     = 25;
  localparam int IDX_W     = 12;
  localparam int WIN       = 5;
  localparam int CENTER    = 2;
  localparam int CFG_IDX_W = 2;

  // Scaled threshold widths: 23*c needs 53 bits (10*max fits in 52), 4*|c| signed needs 51
  localparam int SCL_W = CURV_W + 5;
  localparam int QTR_W = CURV_W + 3;

  // 4e-4 in Q24.24, truncated
  localparam logic [CURV_W-1:0] MAG_FLOOR = CURV_W'(6710);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MAX      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_MIN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SCALE_MODE = 2'd2;

  // Thresholds derived from the configuration registers
  typedef struct packed {
    logic                     mode;
    logic signed [SCL_W-1:0]  max_x10;
    logic signed [SCL_W-1:0]  min_x10;
    logic signed [CURV_W-1:0] max_raw;
    logic [CURV_W-1:0]        min_mag;
  } ced_thr_t;

  typedef logic [WIN-1:0][CURV_W-1:0] curv_win_t;

  // Magnitude of a signed curvature; the most negative value maps to 2^47
  function automatic logic [CURV_W-1:0] curv_mag(input logic [CURV_W-1:0] v);
    return v[CURV_W-1] ? (~v + CURV_W'(1)) : v;
  endfunction

endpackage

FILE: hdl/curvature_extrema_detector.sv
// Curvature extrema detector: five-sample window, point counter, result register.
// Depends on ced_pkg, ced_eval and curvature_extrema_detector_macros.svh.
//
// Usage:
//   Input channel (in_valid/in_stall) takes one curve sample per item: its
//   curvature, arc position and a flag marking the last point of the curve.
//   Output channel (out_valid/out_stall) gives one item per keypoint: index
//   within the curve, curvature and arc position of the keypoint.
//   Configuration channel (cfg_valid/cfg_ready) writes curve_max, curve_min
//   and max_scale_mode; cfg_ready is always high. Write only while idle.
// Timing:
//   One item per cycle while in_stall is low, set by the window shift and compare.
//   The edge that accepts the item completing a window loads the window
//   register and pending flag; the result register loads once it is free.
// Reset:
//   Clears the point counter, the pending flag and the output valid; the
//   configuration registers return to zero (thresholds off).
// Stall:
//   The result register holds while out_stall is high; in_stall rises only
//   when a new keypoint waits behind that held result.
module curvature_extrema_detector (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input item channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [ced_pkg::CURV_W-1:0]    in_curv_sample,
  input  logic [ced_pkg::ARC_W-1:0]            in_arc_pos,
  input  logic                                 in_last_point,
  // Result item channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [ced_pkg::IDX_W-1:0]            out_point_index,
  output logic signed [ced_pkg::CURV_W-1:0]    out_key_curvature,
  output logic [ced_pkg::ARC_W-1:0]            out_key_arc_pos,
  // Configuration write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ced_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ced_pkg::CURV_W-1:0]           cfg_data
);

  `include "curvature_extrema_detector_macros.svh"

  // Configuration registers
  logic signed [ced_pkg::CURV_W-1:0] curve_max_r;
  logic signed [ced_pkg::CURV_W-1:0] curve_min_r;
  logic                              mode_r;
  ced_pkg::ced_thr_t                 thr_r;
  ced_pkg::ced_thr_t                 thr_nxt;
  logic signed [ced_pkg::SCL_W-1:0]  max_ext;
  logic signed [ced_pkg::SCL_W-1:0]  min_ext;

  // Window and counter
  ced_pkg::curv_win_t                curv_win_r;
  logic [ced_pkg::ARC_W-1:0]         arc_win_r [ced_pkg::WIN];
  logic [ced_pkg::CNT_W-1:0]         cnt_r;
  logic [ced_pkg::CNT_W-1:0]         cnt_nxt;
  logic                              pend_r;
  logic                              pend_nxt;
  logic [ced_pkg::IDX_W-1:0]         idx_r;

  // Result register
  logic                              out_valid_r;
  logic [ced_pkg::IDX_W-1:0]         out_idx_r;
  logic [ced_pkg::CURV_W-1:0]        out_curv_r;
  logic [ced_pkg::ARC_W-1:0]         out_arc_r;

  logic                              in_accept;
  logic                              keep;
  logic                              hit;
  logic                              out_free;
  logic                              eligible;

  assign cfg_ready = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      curve_max_r <= '0;
      curve_min_r <= '0;
      mode_r      <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ced_pkg::REG_CURVE_MAX:      curve_max_r <= $signed(cfg_data);
        ced_pkg::REG_CURVE_MIN:      curve_min_r <= $signed(cfg_data);
        ced_pkg::REG_MAX_SCALE_MODE: mode_r      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Derive scaled thresholds, registered behind the configuration registers
  assign max_ext = ced_pkg::SCL_W'(curve_max_r);
  assign min_ext = ced_pkg::SCL_W'(curve_min_r);

  always_comb begin
    thr_nxt.mode    = mode_r;
    thr_nxt.max_x10 = (max_ext <<< 3) + (max_ext <<< 1);
    thr_nxt.min_x10 = (min_ext <<< 3) + (min_ext <<< 1);
    thr_nxt.max_raw = curve_max_r;
    thr_nxt.min_mag = ced_pkg::curv_mag(curve_min_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= '0;
    end else begin
      thr_r <= thr_nxt;
    end
  end

  // Handshake: stall only when a keypoint waits behind a held result
  assign out_free  = !out_valid_r || !out_stall;
  assign hit       = pend_r && keep;
  assign in_stall  = hit && !out_free;
  assign in_accept = in_valid && !in_stall;

  // Advance the point counter; clear after the last point, saturate at the top
  assign eligible = cnt_r >= ced_pkg::CNT_W'(4);

  always_comb begin
    cnt_nxt = cnt_r;
    if (in_accept) begin
      if (in_last_point) begin
        cnt_nxt = '0;
      end else if (cnt_r != ced_pkg::CNT_W'(ced_pkg::MAX_POINTS - 1)) begin
        cnt_nxt = cnt_r + ced_pkg::CNT_W'(1);
      end
    end
  end

  // Hold the pending centre while stalled, otherwise take the new item's status
  assign pend_nxt = in_stall ? pend_r : (in_accept && eligible);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pend_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Shift the window and record the centre index on each accepted item
  always_ff @(posedge clk) begin
    if (in_accept) begin
      for (int k = 0; k < ced_pkg::WIN - 1; k++) begin
        curv_win_r[k] <= curv_win_r[k+1];
        arc_win_r[k]  <= arc_win_r[k+1];
      end
      curv_win_r[ced_pkg::WIN-1] <= in_curv_sample;
      arc_win_r[ced_pkg::WIN-1]  <= in_arc_pos;
      idx_r <= ced_pkg::IDX_W'(cnt_r - ced_pkg::CNT_W'(2));
    end
  end

  // Decide whether the centre is a keypoint
  ced_eval u_eval (
    .curv_win (curv_win_r),
    .thr      (thr_r),
    .keep     (keep)
  );

  // Load the result register, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (hit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hit && out_free) begin
      out_idx_r  <= idx_r;
      out_curv_r <= curv_win_r[ced_pkg::CENTER];
      out_arc_r  <= arc_win_r[ced_pkg::CENTER];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_point_index   = out_idx_r;
  assign out_key_curvature = $signed(out_curv_r);
  assign out_key_arc_pos   = out_arc_r;

  // Checks on the block's own control
  `CED_ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, pend_r && out_valid_r)
  `CED_ASSERT_NEXT(a_last_clears, clk, rst_n, in_accept && in_last_point, cnt_r == '0)
  `CED_ASSERT_SAME(a_out_source, clk, rst_n, $rose(out_valid_r), $past(pend_r))

endmodule

FILE: hdl/ced_eval.sv
// Extremum and threshold decision for the window centre.
// Uses ced_pkg for widths, the threshold struct and the magnitude helper.
module ced_eval (
  input  ced_pkg::curv_win_t curv_win,
  input  ced_pkg::ced_thr_t  thr,
  output logic               keep
);

  logic signed [ced_pkg::CURV_W-1:0] c;
  logic [ced_pkg::CURV_W-1:0]        m;
  logic [ced_pkg::WIN-1:0]           above;
  logic                              ext;
  logic signed [ced_pkg::SCL_W-1:0]  c_ext;
  logic signed [ced_pkg::SCL_W-1:0]  c_x23;
  logic                              pos_ok;
  logic                              neg_ok;
  logic                              floor_ok;

  assign c = $signed(curv_win[ced_pkg::CENTER]);
  assign m = ced_pkg::curv_mag(curv_win[ced_pkg::CENTER]);

  // Compare centre magnitude with each neighbour
  always_comb begin
    for (int k = 0; k < ced_pkg::WIN; k++) begin
      if (k == ced_pkg::CENTER) begin
        above[k] = 1'b1;
      end else begin
        above[k] = m > ced_pkg::curv_mag(curv_win[k]);
      end
    end
  end

  assign ext = &above;

  // Scale the centre by 23 with shifts and adds
  assign c_ext = ced_pkg::SCL_W'(c);
  assign c_x23 = (c_ext <<< 4) + (c_ext <<< 2) + (c_ext <<< 1) + c_ext;

  // c > trunc(max*10/23) and c > |trunc(min/4)| for a positive centre
  assign pos_ok = !c[ced_pkg::CURV_W-1] && (m != '0) &&
                  (c_x23 > $signed(thr.max_x10)) &&
                  ({m, 2'b00} > {2'b00, thr.min_mag});

  // c < trunc(min*10/23) and |c| > trunc(max/4) for a negative centre
  assign neg_ok = c[ced_pkg::CURV_W-1] &&
                  (c_x23 < $signed(thr.min_x10)) &&
                  ($signed({1'b0, m, 2'b00}) > ced_pkg::QTR_W'($signed(thr.max_raw)));

  assign floor_ok = m > ced_pkg::MAG_FLOOR;

  assign keep = ext && (!thr.mode || ((pos_ok || neg_ok) && floor_ok));

endmodule
